@@ rtl/cbor_item_skip_checker_top_assert.svh @@
// assertion macros used by the cbor item checker core
`ifndef CBOR_ITEM_SKIP_CHECKER_TOP_ASSERT_SVH
`define CBOR_ITEM_SKIP_CHECKER_TOP_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define CBIS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CBIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cbis_pkg.sv @@
// shared types and constants for the cbor item checker
package cbis_pkg;

  localparam int DATA_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int ERR_W       = 3;
  localparam int NEST_W      = 4;
  localparam int CFG_W       = 4;
  localparam int ARG_W       = 64;
  localparam int ABL_W       = 4;
  localparam int OUT_TDATA_W = 16;
  localparam int MAX_NEST_DEF = 8;

  localparam logic [CFG_W-1:0] DEPTH_LIMIT_RST = 4'd8;

  // major types
  localparam logic [2:0] MAJ_NINT   = 3'd1;
  localparam logic [2:0] MAJ_TEXT   = 3'd3;
  localparam logic [2:0] MAJ_MAP    = 3'd5;
  localparam logic [2:0] MAJ_TAG    = 3'd6;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;

  // additional info thresholds
  localparam logic [4:0] AI_ARG1 = 5'd24;
  localparam logic [4:0] AI_RSVD = 5'd28;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROG = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 3'd0,
    ERR_TRUNC = 3'd1,
    ERR_RSVD  = 3'd2,
    ERR_UNSUP = 3'd3,
    ERR_DEEP  = 3'd4
  } err_t;

  typedef struct packed {
    logic close;
    logic push;
  } stk_ctl_t;

endpackage

@@ rtl/cbor_item_skip_checker_top.sv @@
// Streaming CBOR well-formedness checker, one encoded byte per beat.
//
// Slave stream: one buffer byte per beat in s_axis_tdata[7:0]; s_axis_tlast
// marks the final byte of the buffer. Master stream: exactly one result beat
// per input beat carrying status, error code and open container count.
// cfg_we/cfg_wdata write the depth limit (greatest nesting level at which an
// item head may begin); write it only while no beats are in flight.
//
// An accepted input beat passes through the input register, then the parse
// step into the result register. Throughput is one byte per cycle while the
// master side takes results, set by the parser update and the parallel pop
// search over the per-level child counters.
//
// Reset (rst, synchronous) empties both registers, returns the parser to
// waiting for an item head at level zero and sets the depth limit to 8.
// When the master side stalls the result beat holds, the input register
// fills, and s_axis_tready drops until the result beat is taken.
module cbor_item_skip_checker_top #(
  parameter int MAX_NEST = cbis_pkg::MAX_NEST_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cbis_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] data_byte
  input  logic [cbis_pkg::DATA_W-1:0]         s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [4:2] error_code, [8:5] nesting_level, [15:9] zero
  output logic [cbis_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int LW = $clog2(MAX_NEST + 1);
  localparam int PAD_W = cbis_pkg::OUT_TDATA_W - cbis_pkg::STATUS_W
                         - cbis_pkg::ERR_W - cbis_pkg::NEST_W;

  logic [cbis_pkg::CFG_W-1:0]    depth_limit;
  logic                          in_valid;
  logic [cbis_pkg::DATA_W-1:0]   in_byte;
  logic                          in_end;
  logic                          core_ready;

  cbis_pkg::status_t             status;
  cbis_pkg::err_t                error_code;
  logic [cbis_pkg::NEST_W-1:0]   nesting_level;

  cbis_pkg::stk_ctl_t            stk_ctl;
  logic [cbis_pkg::ARG_W-1:0]    stk_val;
  logic [LW-1:0]                 open_levels;
  logic                          stk_done;
  logic [LW-1:0]                 stk_keep_open;

  assign s_axis_tready = !in_valid || core_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= cbis_pkg::DEPTH_LIMIT_RST;
      in_valid    <= 1'b0;
      in_byte     <= '0;
      in_end      <= 1'b0;
    end else begin
      if (cfg_we) begin
        depth_limit <= cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_axis_tdata;
        in_end   <= s_axis_tlast;
      end else if (core_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  cbis_core #(
    .MAX_NEST (MAX_NEST),
    .LW       (LW)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .depth_limit   (depth_limit),
    .in_valid      (in_valid),
    .in_byte       (in_byte),
    .in_end        (in_end),
    .in_ready      (core_ready),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .status        (status),
    .error_code    (error_code),
    .nesting_level (nesting_level),
    .stk_ctl       (stk_ctl),
    .stk_val       (stk_val),
    .open_levels   (open_levels),
    .stk_done      (stk_done),
    .stk_keep_open (stk_keep_open)
  );

  cbis_stack #(
    .MAX_NEST (MAX_NEST),
    .LW       (LW)
  ) u_stack (
    .clk         (clk),
    .ctl         (stk_ctl),
    .open_levels (open_levels),
    .push_val    (stk_val),
    .done        (stk_done),
    .keep_open   (stk_keep_open)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, nesting_level, error_code, status};

endmodule

@@ rtl/cbis_stack.sv @@
// per-level child counters with parallel pop search
module cbis_stack #(
  parameter int MAX_NEST = cbis_pkg::MAX_NEST_DEF,
  parameter int LW       = $clog2(MAX_NEST + 1)
) (
  input  logic                         clk,
  input  cbis_pkg::stk_ctl_t           ctl,
  input  logic [LW-1:0]                open_levels,
  input  logic [cbis_pkg::ARG_W-1:0]   push_val,
  output logic                         done,
  output logic [LW-1:0]                keep_open
);

  logic [cbis_pkg::ARG_W-1:0] rem [MAX_NEST];
  logic [MAX_NEST-1:0]        keep;
  logic [MAX_NEST-1:0]        dec;

  // a level survives the pop if it is open and not on its last child
  always_comb begin
    for (int i = 0; i < MAX_NEST; i++) begin
      keep[i] = (LW'(i) < open_levels) && (rem[i] != cbis_pkg::ARG_W'(1));
    end
  end

  // highest surviving level takes the decrement, everything above it pops
  always_comb begin
    logic seen;
    seen      = 1'b0;
    dec       = '0;
    keep_open = '0;
    for (int i = MAX_NEST - 1; i >= 0; i--) begin
      if (keep[i] && !seen) begin
        dec[i]    = 1'b1;
        keep_open = LW'(i + 1);
        seen      = 1'b1;
      end
    end
    done = !seen;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_NEST; i++) begin
      if (ctl.push && open_levels == LW'(i)) begin
        rem[i] <= push_val;
      end else if (ctl.close && dec[i]) begin
        rem[i] <= rem[i] - cbis_pkg::ARG_W'(1);
      end
    end
  end

endmodule

@@ rtl/cbis_core.sv @@
// byte parser state, result register and stack control
module cbis_core #(
  parameter int MAX_NEST = cbis_pkg::MAX_NEST_DEF,
  parameter int LW       = $clog2(MAX_NEST + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cbis_pkg::CFG_W-1:0]    depth_limit,
  input  logic                          in_valid,
  input  logic [cbis_pkg::DATA_W-1:0]   in_byte,
  input  logic                          in_end,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cbis_pkg::status_t             status,
  output cbis_pkg::err_t                error_code,
  output logic [cbis_pkg::NEST_W-1:0]   nesting_level,
  output cbis_pkg::stk_ctl_t            stk_ctl,
  output logic [cbis_pkg::ARG_W-1:0]    stk_val,
  output logic [LW-1:0]                 open_levels,
  input  logic                          stk_done,
  input  logic [LW-1:0]                 stk_keep_open
);

  localparam int CW = (LW > cbis_pkg::CFG_W) ? LW : cbis_pkg::CFG_W;

  typedef enum logic [1:0] {
    PH_HEAD    = 2'd0,
    PH_ARG     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t                         phase, phase_next;
  logic [2:0]                     head_major, head_major_next;
  logic [cbis_pkg::ABL_W-1:0]     arg_bytes_left, arg_bytes_left_next;
  logic [cbis_pkg::ARG_W-1:0]     arg_value, arg_value_next;
  logic [cbis_pkg::ARG_W-1:0]     payload_left, payload_left_next;
  logic [LW-1:0]                  open_levels_next;

  cbis_pkg::status_t              status_next;
  cbis_pkg::err_t                 err;
  logic [cbis_pkg::NEST_W-1:0]    nesting_next;

  logic                           fire;
  logic [2:0]                     major;
  logic [4:0]                     ai;
  logic [CW-1:0]                  open_ext;
  logic [CW-1:0]                  eff_limit;
  logic [cbis_pkg::ARG_W-1:0]     arg_shift;
  logic [cbis_pkg::ARG_W-1:0]     count;
  logic [cbis_pkg::ARG_W-1:0]     res_arg;
  logic [2:0]                     res_major;
  logic                           do_res;
  logic                           do_close;
  logic                           do_push;
  logic                           item_done;

  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;
  assign major     = in_byte[7:5];
  assign ai        = in_byte[4:0];
  assign open_ext  = CW'(open_levels);
  assign arg_shift = {arg_value[cbis_pkg::ARG_W-cbis_pkg::DATA_W-1:0], in_byte};

  always_comb begin
    if (CW'(depth_limit) > CW'(MAX_NEST)) begin
      eff_limit = CW'(MAX_NEST);
    end else begin
      eff_limit = CW'(depth_limit);
    end
  end

  always_comb begin
    phase_next          = phase;
    head_major_next     = head_major;
    arg_bytes_left_next = arg_bytes_left;
    arg_value_next      = arg_value;
    payload_left_next   = payload_left;
    open_levels_next    = open_levels;
    err                 = cbis_pkg::ERR_NONE;
    item_done           = 1'b0;
    do_res              = 1'b0;
    do_close            = 1'b0;
    do_push             = 1'b0;
    res_major           = head_major;
    res_arg             = arg_value;
    count               = '0;
    stk_val             = '0;

    case (phase)
      PH_ARG: begin
        arg_value_next = arg_shift;
        if (arg_bytes_left != '0) begin
          arg_bytes_left_next = arg_bytes_left - cbis_pkg::ABL_W'(1);
        end
        if (arg_bytes_left_next == '0) begin
          do_res  = 1'b1;
          res_arg = arg_shift;
        end
      end
      PH_PAYLOAD: begin
        if (payload_left != '0) begin
          payload_left_next = payload_left - cbis_pkg::ARG_W'(1);
        end
        if (payload_left_next == '0) begin
          do_close = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HEAD;
        if (open_ext > eff_limit) begin
          err = cbis_pkg::ERR_DEEP;
        end else if (major == cbis_pkg::MAJ_TAG ||
                     (major == cbis_pkg::MAJ_SIMPLE && ai >= cbis_pkg::AI_ARG1)) begin
          err = cbis_pkg::ERR_UNSUP;
        end else if (major == cbis_pkg::MAJ_SIMPLE) begin
          do_close = 1'b1;
        end else if (ai >= cbis_pkg::AI_RSVD) begin
          err = cbis_pkg::ERR_RSVD;
        end else if (ai < cbis_pkg::AI_ARG1) begin
          head_major_next = major;
          arg_value_next  = cbis_pkg::ARG_W'(ai);
          do_res          = 1'b1;
          res_major       = major;
          res_arg         = cbis_pkg::ARG_W'(ai);
        end else begin
          head_major_next = major;
          arg_value_next  = '0;
          phase_next      = PH_ARG;
          // 1, 2, 4 or 8 argument bytes follow
          arg_bytes_left_next = cbis_pkg::ABL_W'(1) << ai[1:0];
        end
      end
    endcase

    if (do_res) begin
      // map count is pairs of children, wrapping at 64 bits
      if (res_major == cbis_pkg::MAJ_MAP) begin
        count = {res_arg[cbis_pkg::ARG_W-2:0], 1'b0};
      end else begin
        count = res_arg;
      end
      if (res_major <= cbis_pkg::MAJ_NINT) begin
        do_close = 1'b1;
      end else if (res_major <= cbis_pkg::MAJ_TEXT) begin
        if (res_arg == '0) begin
          do_close = 1'b1;
        end else begin
          payload_left_next = res_arg;
          phase_next        = PH_PAYLOAD;
        end
      end else if (count == '0) begin
        do_close = 1'b1;
      end else if (open_ext >= eff_limit) begin
        err = cbis_pkg::ERR_DEEP;
      end else begin
        do_push          = 1'b1;
        stk_val          = count;
        open_levels_next = open_levels + LW'(1);
        phase_next       = PH_HEAD;
      end
    end

    if (do_close) begin
      phase_next = PH_HEAD;
      if (stk_done) begin
        item_done = 1'b1;
      end else begin
        open_levels_next = stk_keep_open;
      end
    end

    if (err == cbis_pkg::ERR_NONE && !item_done && in_end) begin
      err = cbis_pkg::ERR_TRUNC;
    end

    if (err != cbis_pkg::ERR_NONE) begin
      status_next         = cbis_pkg::ST_ERR;
      nesting_next        = '0;
      phase_next          = PH_HEAD;
      arg_bytes_left_next = '0;
      payload_left_next   = '0;
      open_levels_next    = '0;
    end else if (item_done) begin
      status_next      = cbis_pkg::ST_DONE;
      nesting_next     = '0;
      phase_next       = PH_HEAD;
      open_levels_next = '0;
    end else begin
      status_next  = cbis_pkg::ST_PROG;
      nesting_next = cbis_pkg::NEST_W'(open_levels_next);
    end

    stk_ctl.close = fire && do_close;
    stk_ctl.push  = fire && do_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEAD;
      head_major     <= '0;
      arg_bytes_left <= '0;
      arg_value      <= '0;
      payload_left   <= '0;
      open_levels    <= '0;
      out_valid      <= 1'b0;
      status         <= cbis_pkg::ST_PROG;
      error_code     <= cbis_pkg::ERR_NONE;
      nesting_level  <= '0;
    end else begin
      if (fire) begin
        phase          <= phase_next;
        head_major     <= head_major_next;
        arg_bytes_left <= arg_bytes_left_next;
        arg_value      <= arg_value_next;
        payload_left   <= payload_left_next;
        open_levels    <= open_levels_next;
        status         <= status_next;
        error_code     <= err;
        nesting_level  <= nesting_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "cbor_item_skip_checker_top_assert.svh"

  `CBIS_ASSERT(a_err_code, clk, rst, !out_valid || ((status == cbis_pkg::ST_ERR) == (error_code != cbis_pkg::ERR_NONE)), "error code does not match status")
  `CBIS_ASSERT(a_end_level, clk, rst, !out_valid || status == cbis_pkg::ST_PROG || nesting_level == '0, "nonzero level on a finished beat")
  `CBIS_ASSERT(a_arg_count, clk, rst, phase != PH_ARG || arg_bytes_left != '0, "argument phase with no bytes owed")
  `CBIS_ASSERT(a_stk_excl, clk, rst, !(stk_ctl.close && stk_ctl.push), "stack push and pop together")
  `CBIS_ASSERT_NEXT(a_err_clear, clk, rst, fire && err != cbis_pkg::ERR_NONE, phase == PH_HEAD && open_levels == '0 && arg_bytes_left == '0, "state not cleared after error")

endmodule

@@ tb/tb_cbor_item_skip_checker_top.sv @@
// self-checking testbench for the streaming cbor well-formedness checker
module tb_cbor_item_skip_checker_top;

  localparam int NEST_MAX = cbis_pkg::MAX_NEST_DEF;
  localparam logic [2:0] MAJ_UINT  = 3'd0;
  localparam logic [2:0] MAJ_BYTES = 3'd2;
  localparam logic [2:0] MAJ_ARRAY = 3'd4;
  localparam int BEATS_PER_SETTING = 165;

  typedef enum logic [1:0] {
    AWAIT_HEAD,
    ARG_BYTES,
    STR_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    cbis_pkg::status_t           st;
    cbis_pkg::err_t              code;
    logic [cbis_pkg::NEST_W-1:0] lvl;
  } verdict_t;

  // tracks the parser state byte by byte and queues the verdict each byte should give
  class wellformed_tracker;
    logic [cbis_pkg::CFG_W-1:0] depth_limit;
    parse_phase_t               phase;
    logic [2:0]                 major;
    logic [cbis_pkg::ABL_W-1:0] arg_left;
    logic [63:0]                arg_value;
    logic [63:0]                payload_left;
    int                         open_levels;
    logic [63:0]                owed [NEST_MAX];
    cbis_pkg::err_t             fault;
    verdict_t                   expected_verdicts [$];
    int                         mismatches;

    function new();
      depth_limit  = cbis_pkg::DEPTH_LIMIT_RST;
      phase        = AWAIT_HEAD;
      major        = MAJ_UINT;
      arg_left     = '0;
      arg_value    = '0;
      payload_left = '0;
      open_levels  = 0;
      mismatches   = 0;
      foreach (owed[i]) owed[i] = '0;
    endfunction

    function void set_limit(logic [cbis_pkg::CFG_W-1:0] v);
      depth_limit = v;
    endfunction

    function int eff_limit();
      return (depth_limit > NEST_MAX) ? NEST_MAX : int'(depth_limit);
    endfunction

    // an item ended; pops every container whose last child it was
    function bit close_item();
      int idx;
      phase = AWAIT_HEAD;
      while (open_levels > 0) begin
        idx = open_levels - 1;
        if (idx >= NEST_MAX) return 1'b0;
        owed[idx] = owed[idx] - 64'd1;
        if (owed[idx] != 0) return 1'b0;
        open_levels--;
      end
      return 1'b1;
    endfunction

    function cbis_pkg::status_t resolve_arg();
      logic [63:0] n;
      if (major <= cbis_pkg::MAJ_NINT)
        return close_item() ? cbis_pkg::ST_DONE : cbis_pkg::ST_PROG;
      if (major <= cbis_pkg::MAJ_TEXT) begin
        if (arg_value == 0) return close_item() ? cbis_pkg::ST_DONE : cbis_pkg::ST_PROG;
        payload_left = arg_value;
        phase = STR_PAYLOAD;
        return cbis_pkg::ST_PROG;
      end
      // map counts wrap at 64 bits when doubled
      n = (major == cbis_pkg::MAJ_MAP) ? (arg_value << 1) : arg_value;
      if (n == 0) return close_item() ? cbis_pkg::ST_DONE : cbis_pkg::ST_PROG;
      if (open_levels >= eff_limit()) begin
        fault = cbis_pkg::ERR_DEEP;
        return cbis_pkg::ST_ERR;
      end
      owed[open_levels] = n;
      open_levels++;
      phase = AWAIT_HEAD;
      return cbis_pkg::ST_PROG;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      cbis_pkg::status_t st;
      logic [2:0]        maj;
      logic [4:0]        ai;
      verdict_t          v;
      st    = cbis_pkg::ST_PROG;
      fault = cbis_pkg::ERR_NONE;
      maj   = b[7:5];
      ai    = b[4:0];
      case (phase)
        ARG_BYTES: begin
          arg_value = {arg_value[55:0], b};
          if (arg_left > 0) arg_left--;
          if (arg_left == 0) st = resolve_arg();
        end
        STR_PAYLOAD: begin
          if (payload_left > 0) payload_left--;
          if (payload_left == 0) st = close_item() ? cbis_pkg::ST_DONE : cbis_pkg::ST_PROG;
        end
        default: begin
          phase = AWAIT_HEAD;
          if (open_levels > eff_limit()) begin
            st = cbis_pkg::ST_ERR;
            fault = cbis_pkg::ERR_DEEP;
          end else if (maj == cbis_pkg::MAJ_TAG ||
                       (maj == cbis_pkg::MAJ_SIMPLE && ai >= cbis_pkg::AI_ARG1)) begin
            st = cbis_pkg::ST_ERR;
            fault = cbis_pkg::ERR_UNSUP;
          end else if (maj == cbis_pkg::MAJ_SIMPLE) begin
            st = close_item() ? cbis_pkg::ST_DONE : cbis_pkg::ST_PROG;
          end else if (ai >= cbis_pkg::AI_RSVD) begin
            st = cbis_pkg::ST_ERR;
            fault = cbis_pkg::ERR_RSVD;
          end else if (ai < cbis_pkg::AI_ARG1) begin
            major = maj;
            arg_value = 64'(ai);
            st = resolve_arg();
          end else begin
            major = maj;
            arg_value = '0;
            arg_left = cbis_pkg::ABL_W'(1) << (ai - cbis_pkg::AI_ARG1);
            phase = ARG_BYTES;
          end
        end
      endcase
      if (st == cbis_pkg::ST_PROG && last) begin
        st = cbis_pkg::ST_ERR;
        fault = cbis_pkg::ERR_TRUNC;
      end
      v.st = st;
      v.code = cbis_pkg::ERR_NONE;
      v.lvl = '0;
      if (st == cbis_pkg::ST_ERR) begin
        v.code = fault;
        phase = AWAIT_HEAD;
        arg_left = '0;
        payload_left = '0;
        open_levels = 0;
      end else if (st == cbis_pkg::ST_DONE) begin
        phase = AWAIT_HEAD;
        open_levels = 0;
      end else begin
        v.lvl = cbis_pkg::NEST_W'(open_levels);
      end
      expected_verdicts.push_back(v);
    endfunction

    function void check_result(logic [cbis_pkg::OUT_TDATA_W-1:0] word);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h with nothing pending", word);
        return;
      end
      v = expected_verdicts.pop_front();
      if (word[1:0] != v.st || word[4:2] != v.code || word[8:5] != v.lvl
          || word[15:9] != '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected status %0d code %0d level %0d,",
                   v.st, v.code, v.lvl,
                   " got status %0d code %0d level %0d pad %h",
                   word[1:0], word[4:2], word[8:5], word[15:9]);
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [cbis_pkg::CFG_W-1:0]       cfg_wdata;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [cbis_pkg::DATA_W-1:0]      s_axis_tdata;
  logic                             s_axis_tlast;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [cbis_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  wellformed_tracker sb;
  logic [7:0]        enc_bytes [$];
  int                beats_sent;
  bit                src_burst;
  bit                sink_burst;
  int                limit_steps [8] = '{8, 2, 15, 0, 1, 9, 5, 8};

  cbor_item_skip_checker_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(b, last);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic flush_bytes(input logic mark_end);
    foreach (enc_bytes[i]) send_beat(enc_bytes[i], mark_end && i == enc_bytes.size() - 1);
    enc_bytes.delete();
  endtask

  // no beats in flight, plus a margin for the two-stage pipeline
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [cbis_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return 64'($urandom_range(0, 23));
      1:       return 64'($urandom_range(0, 255));
      2:       return 64'($urandom_range(0, 65535));
      3:       return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // head with argument, sometimes in a wider encoding than needed
  task automatic emit_head(input logic [2:0] maj, input logic [63:0] val);
    int k;
    int kmin;
    if (val < 24 && $urandom_range(0, 3) != 0) begin
      enc_bytes.push_back({maj, val[4:0]});
      return;
    end
    kmin = (val < 64'h100) ? 0 : (val < 64'h1_0000) ? 1 : (val < 64'h1_0000_0000) ? 2 : 3;
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(kmin, 3) : kmin;
    enc_bytes.push_back({maj, cbis_pkg::AI_ARG1 + 5'(k)});
    for (int i = (1 << k) - 1; i >= 0; i--) enc_bytes.push_back(val[8*i +: 8]);
  endtask

  task automatic build_item(input int lvl);
    int kind;
    int cnt;
    kind = (lvl >= 9 || enc_bytes.size() > 48) ? $urandom_range(0, 5) : $urandom_range(0, 9);
    case (kind)
      0, 1: emit_head(MAJ_UINT, pick_value());
      2:    emit_head(cbis_pkg::MAJ_NINT, pick_value());
      3, 4: begin
        cnt = $urandom_range(0, 6);
        emit_head(kind == 3 ? MAJ_BYTES : cbis_pkg::MAJ_TEXT, 64'(cnt));
        repeat (cnt) enc_bytes.push_back(8'($urandom));
      end
      5:    enc_bytes.push_back({cbis_pkg::MAJ_SIMPLE, 5'($urandom_range(0, 23))});
      6, 7: begin
        cnt = (lvl < 2) ? $urandom_range(0, 3) : $urandom_range(0, 2);
        emit_head(MAJ_ARRAY, 64'(cnt));
        repeat (cnt) build_item(lvl + 1);
      end
      default: begin
        cnt = $urandom_range(0, 2);
        emit_head(cbis_pkg::MAJ_MAP, 64'(cnt));
        repeat (2 * cnt) build_item(lvl + 1);
      end
    endcase
  endtask

  task automatic random_buffer();
    int r;
    int n;
    int cut;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      n = $urandom_range(1, 3);
      repeat (n) build_item(0);
      flush_bytes(1'b1);
    end else if (r < 75) begin
      // single-child chain to reach the depth limit
      n = $urandom_range(1, 10);
      repeat (n) emit_head($urandom_range(0, 1) ? MAJ_ARRAY : cbis_pkg::MAJ_MAP, 64'd1);
      repeat (n) build_item(n);
      flush_bytes(1'b1);
    end else if (r < 85) begin
      build_item(0);
      if (enc_bytes.size() > 1) begin
        cut = $urandom_range(1, enc_bytes.size() - 1);
        enc_bytes = enc_bytes[0:cut-1];
      end
      flush_bytes(1'b1);
    end else if (r < 93) begin
      repeat ($urandom_range(1, 6)) enc_bytes.push_back(8'($urandom));
      flush_bytes(1'($urandom_range(0, 1)));
    end else begin
      build_item(0);
      enc_bytes[$urandom_range(0, enc_bytes.size() - 1)] = 8'($urandom);
      flush_bytes(1'b1);
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    beats_sent    = 0;
    src_burst     = 1'b0;
    sink_burst    = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed items under the reset limit
    enc_bytes = {8'h00};                          flush_bytes(1'b0);
    enc_bytes = {8'h19, 8'hff, 8'hff};            flush_bytes(1'b0);
    enc_bytes = {8'h40};                          flush_bytes(1'b0);
    enc_bytes = {8'h61, 8'h5a};                   flush_bytes(1'b0);
    enc_bytes = {8'ha1, 8'h01, 8'hf4};            flush_bytes(1'b0);
    enc_bytes = {8'hc0};                          flush_bytes(1'b0);
    enc_bytes = {8'hf8};                          flush_bytes(1'b0);
    enc_bytes = {8'hff};                          flush_bytes(1'b0);
    enc_bytes = {8'h1f};                          flush_bytes(1'b0);
    enc_bytes = {8'h5f};                          flush_bytes(1'b0);
    enc_bytes = {8'h82};                          flush_bytes(1'b1);
    // map count of 2^63 doubles to zero and completes at its head
    enc_bytes = {8'hbb, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    flush_bytes(1'b0);
    wait_drained();
    write_limit(4'd0);
    enc_bytes = {8'h81, 8'h01};                   flush_bytes(1'b0);
    wait_drained();
    // open three levels, then lower the limit beneath them
    write_limit(4'd8);
    enc_bytes = {8'h81, 8'h81, 8'h81};            flush_bytes(1'b0);
    wait_drained();
    write_limit(4'd1);
    enc_bytes = {8'h01};                          flush_bytes(1'b0);

    foreach (limit_steps[p]) begin
      int start;
      wait_drained();
      write_limit(cbis_pkg::CFG_W'(limit_steps[p]));
      start = beats_sent;
      while (beats_sent - start < BEATS_PER_SETTING) random_buffer();
    end
    wait_drained();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
